[design/nntt_pkg.sv]
// Shared types and constants for the nearest-neighbor track table.
// No dependencies; every other design file imports this package.
package nntt_pkg;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_MATCHED   = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_RANGE     = 3'd3;
  localparam logic [2:0] ST_SMALL     = 3'd4;
  localparam logic [2:0] ST_INVALID   = 3'd5;
  localparam logic [2:0] ST_DISCARDED = 3'd6;

  localparam logic [2:0] REG_AREA_FLOOR = 3'd0;
  localparam logic [2:0] REG_MARGIN     = 3'd1;
  localparam logic [2:0] REG_MAX_X      = 3'd2;
  localparam logic [2:0] REG_MAX_Y      = 3'd3;
  localparam logic [2:0] REG_MAX_Z      = 3'd4;
  localparam logic [2:0] REG_LOW        = 3'd5;
  localparam logic [2:0] REG_KILL       = 3'd6;

  typedef struct packed {
    logic [30:0]        area_floor;
    logic [15:0]        match_margin;
    logic signed [15:0] max_x;
    logic signed [15:0] max_y;
    logic signed [15:0] max_z;
    logic signed [15:0] low_limit;
    logic [31:0]        kill_timeout;
  } cfg_t;

endpackage

[design/nearest_neighbor_track_table.sv]
// Top level of the nearest-neighbor track table: APB registers, sequencer, track store.
// Depends on nntt_pkg and nntt_sqdist.
//
// Channel  | Direction | Handshake
// s_axis   | in        | tvalid/tready, tdata = box, tlast = last box of frame
// m_axis   | out       | tvalid/tready, tdata = status, index, id, removed count
// apb      | in        | psel/penable/pwrite, pready always high
//
// An item is compared with the N tracks held unless no search is made (size,
// sign, abort or range rejects, and inserts into an empty table or a frame that
// began empty); a frame-end sweep walks the tracks then held. The time taken is
// set by the single shared squared-distance unit, which handles one axis of one
// track per cycle with a compare step after each track, and by the sweep walking
// the store one entry per cycle. Reset is synchronous and clears control state
// and configuration registers. A stalled result holds in the output register;
// the input is not ready until the result is taken.
module nearest_neighbor_track_table
  import nntt_pkg::*;
#(
  parameter int TABLE_DEPTH = 9
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // x_center[15:0], y_center[31:16], depth[47:32], box_height[63:48],
  // box_width[79:64], frame_time[111:80]
  input  logic [111:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2:0], entry_index[6:3], entry_id[38:7], removed_count[42:39], zero fill
  output logic [47:0]  m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIST  = 3'd2;
  localparam logic [2:0] S_DONE  = 3'd3;
  localparam logic [2:0] S_SWEEP = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  cfg_t cfg;

  // Configuration registers.
  logic       wr_en;
  logic [2:0] reg_idx;
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.area_floor   <= '0;
      cfg.match_margin <= '0;
      cfg.max_x        <= 16'sd32767;
      cfg.max_y        <= 16'sd32767;
      cfg.max_z        <= 16'sd32767;
      cfg.low_limit    <= -16'sd32768;
      cfg.kill_timeout <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_AREA_FLOOR: cfg.area_floor   <= pwdata[30:0];
        REG_MARGIN:     cfg.match_margin <= pwdata[15:0];
        REG_MAX_X:      cfg.max_x        <= pwdata[15:0];
        REG_MAX_Y:      cfg.max_y        <= pwdata[15:0];
        REG_MAX_Z:      cfg.max_z        <= pwdata[15:0];
        REG_LOW:        cfg.low_limit    <= pwdata[15:0];
        REG_KILL:       cfg.kill_timeout <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_AREA_FLOOR: prdata = {1'b0, cfg.area_floor};
      REG_MARGIN:     prdata = {16'd0, cfg.match_margin};
      REG_MAX_X:      prdata = {{16{cfg.max_x[15]}}, cfg.max_x};
      REG_MAX_Y:      prdata = {{16{cfg.max_y[15]}}, cfg.max_y};
      REG_MAX_Z:      prdata = {{16{cfg.max_z[15]}}, cfg.max_z};
      REG_LOW:        prdata = {{16{cfg.low_limit[15]}}, cfg.low_limit};
      REG_KILL:       prdata = cfg.kill_timeout;
      default:        prdata = '0;
    endcase
  end

  // Track store, one flip-flop row per entry.
  logic signed [15:0] track_x [TABLE_DEPTH];
  logic signed [15:0] track_y [TABLE_DEPTH];
  logic signed [15:0] track_z [TABLE_DEPTH];
  logic [31:0]        track_id [TABLE_DEPTH];
  logic [31:0]        track_seen_time [TABLE_DEPTH];

  // Control state.
  logic [2:0]  state;
  logic [CW-1:0] track_count;
  logic [31:0] next_id;
  logic        mid_frame, frame_began_empty, frame_aborted;

  // Captured box.
  logic signed [15:0] bx, by, bz, bh, bw;
  logic [31:0] now;
  logic        last;

  // Search and sweep.
  logic [CW-1:0] scan;
  logic [1:0]    axis;
  logic [CW-1:0] keep;
  logic [IW-1:0] best;
  logic          best_ok;
  logic [34:0]   best_d;
  logic [3:0]    removed;

  // Result register.
  logic [2:0]  res_status;
  logic [3:0]  res_index;
  logic [31:0] res_id;

  // Shared distance unit: operand chosen by the axis counter.
  logic [IW-1:0]      scan_i;
  logic signed [15:0] da, db;
  logic               dclear, den;
  logic [34:0]        dsum;
  assign scan_i = scan[IW-1:0];
  always_comb begin
    case (axis)
      2'd0:    begin da = bx; db = track_x[scan_i]; end
      2'd1:    begin da = by; db = track_y[scan_i]; end
      default: begin da = bz; db = track_z[scan_i]; end
    endcase
  end
  assign dclear = (state == S_CHECK);
  assign den    = (state == S_DIST);

  nntt_sqdist u_dist (
    .clk    (clk),
    .clear  (dclear || (den && axis == 2'd3)),
    .enable (den),
    .a      (da),
    .b      (db),
    .sum    (dsum)
  );

  // Checks made once per box.
  logic signed [31:0] area;
  logic               too_small, invalid, out_range;
  logic signed [17:0] m18;
  assign area      = bh * bw;
  assign too_small = $signed({area[31], area}) < $signed({2'b00, cfg.area_floor});
  assign invalid   = bx[15] || by[15] || bz[15] || bh[15] || bw[15];
  assign m18       = $signed({2'b00, cfg.match_margin});
  assign out_range = (18'(bx) + m18 > 18'(cfg.max_x)) || (18'(by) + m18 > 18'(cfg.max_y))
                  || (18'(bz) + m18 > 18'(cfg.max_z)) || (18'(bx) - m18 < 18'(cfg.low_limit))
                  || (18'(by) - m18 < 18'(cfg.low_limit))
                  || (18'(bz) - m18 < 18'(cfg.low_limit));
  logic [31:0] margin_sq;
  assign margin_sq = cfg.match_margin * cfg.match_margin;

  logic began_empty_eff, aborted_eff;
  assign began_empty_eff = frame_began_empty;
  assign aborted_eff     = frame_aborted;

  logic [31:0] age;
  assign age = now - track_seen_time[scan_i];

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = {5'd0, removed, res_id, res_index, res_status};

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      track_count       <= '0;
      next_id           <= '0;
      mid_frame         <= 1'b0;
      frame_began_empty <= 1'b0;
      frame_aborted     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            {now, bw, bh, bz, by, bx} <= s_axis_tdata;
            last <= s_axis_tlast;
            if (!mid_frame) begin
              mid_frame         <= 1'b1;
              frame_began_empty <= (track_count == '0);
              frame_aborted     <= 1'b0;
            end
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          res_index <= '0;
          res_id    <= '0;
          removed   <= '0;
          scan      <= '0;
          axis      <= '0;
          best_ok   <= 1'b0;
          state     <= S_DONE;
          if (aborted_eff) begin
            res_status <= ST_DISCARDED;
          end else if (too_small) begin
            res_status <= ST_SMALL;
          end else if (invalid) begin
            res_status    <= ST_INVALID;
            frame_aborted <= 1'b1;
          end else if (!began_empty_eff && out_range) begin
            res_status <= ST_RANGE;
          end else if (!began_empty_eff && track_count != '0) begin
            res_status <= ST_INSERTED;
            state      <= S_DIST;
          end else begin
            res_status <= ST_INSERTED;
          end
        end
        S_DIST: begin
          // On axis 3 the sum holds all three squares; the unit clears behind it.
          if (axis == 2'd3) begin
            if (!best_ok || dsum < best_d) begin
              best_ok <= 1'b1;
              best    <= scan_i;
              best_d  <= dsum;
            end
            axis <= '0;
            if (scan + 1'b1 == track_count) begin
              state <= S_DONE;
            end
            scan <= scan + 1'b1;
          end else begin
            axis <= axis + 2'd1;
          end
        end
        S_DONE: begin
          state <= S_OUT;
          if (res_status == ST_INSERTED) begin
            if (best_ok && best_d <= 35'(margin_sq)) begin
              res_status            <= ST_MATCHED;
              res_index             <= 4'(best);
              res_id                <= track_id[best];
              track_seen_time[best] <= now;
              next_id               <= next_id + 32'd1;
            end else if (track_count >= CW'(TABLE_DEPTH)) begin
              res_status <= ST_FULL;
            end else begin
              track_x[track_count[IW-1:0]]         <= bx;
              track_y[track_count[IW-1:0]]         <= by;
              track_z[track_count[IW-1:0]]         <= bz;
              track_id[track_count[IW-1:0]]        <= next_id;
              track_seen_time[track_count[IW-1:0]] <= now;
              res_index   <= 4'(track_count);
              res_id      <= next_id;
              next_id     <= next_id + 32'd1;
              track_count <= track_count + 1'b1;
            end
          end
          if (last) begin
            mid_frame <= 1'b0;
            scan      <= '0;
            keep      <= '0;
            if (!frame_began_empty && !(frame_aborted || res_status == ST_INVALID)) begin
              state <= S_SWEEP;
            end
          end
        end
        S_SWEEP: begin
          // Count here still reflects any insert made in S_DONE.
          if (scan == track_count) begin
            track_count <= keep;
            state       <= S_OUT;
          end else begin
            if (age > cfg.kill_timeout) begin
              removed <= removed + 4'd1;
            end else begin
              track_x[keep[IW-1:0]]         <= track_x[scan_i];
              track_y[keep[IW-1:0]]         <= track_y[scan_i];
              track_z[keep[IW-1:0]]         <= track_z[scan_i];
              track_id[keep[IW-1:0]]        <= track_id[scan_i];
              track_seen_time[keep[IW-1:0]] <= track_seen_time[scan_i];
              keep <= keep + 1'b1;
            end
            scan <= scan + 1'b1;
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The table never holds more tracks than it has rows.
  a_count: assert property (@(posedge clk) disable iff (rst)
    track_count <= CW'(TABLE_DEPTH)) else $error("track count overflow");

  // A result is followed by a return to idle once taken.
  a_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready |=> s_axis_tready) else $error("no return to idle");

  // Input is never accepted while a result is pending.
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid)) else $error("accept during result");

endmodule

[design/nntt_sqdist.sv]
// Shared squared-distance unit: one axis difference squared and accumulated per cycle while enabled.
// Depends on nntt_pkg.
module nntt_sqdist
  import nntt_pkg::*;
(
  input  logic               clk,
  input  logic               clear,
  input  logic               enable,
  input  logic signed [15:0] a,
  input  logic signed [15:0] b,
  output logic [34:0]        sum
);

  logic signed [16:0] diff;
  logic signed [33:0] product;
  logic [33:0]        square;

  assign diff    = 17'(a) - 17'(b);
  assign product = diff * diff;
  assign square  = unsigned'(product);

  always_ff @(posedge clk) begin
    if (clear) begin
      sum <= '0;
    end else if (enable) begin
      sum <= sum + 35'(square);
    end
  end

endmodule
